### hdl/brt_pkg.sv
// Shared constants, command codes and types of the bounded ranking table.
package brt_pkg;

   // Defaults of the top-level parameters
   localparam int DEF_POOL_DEPTH = 64;
   localparam int DEF_KEY_BITS   = 16;

   // Fixed field widths
   localparam int CMD_W      = 3;
   localparam int KEY_PORT_W = 16;
   localparam int SCORE_W    = 32;
   localparam int RANK_W     = 7;
   localparam int PSIZE_W    = 7;
   localparam int CSR_IDX_W  = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_UPDATE     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RANK_KEY   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RANK_SCORE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_AT_RANK    = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SCORE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SCORE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE = 2'd2;

   // Register reset values
   localparam logic signed [SCORE_W-1:0] MIN_SCORE_RST = 32'sh8000_0000;
   localparam logic signed [SCORE_W-1:0] MAX_SCORE_RST = 32'sh7FFF_FFFF;
   localparam logic [PSIZE_W-1:0]        POOL_SIZE_RST = 7'd64;

   // Result of the shared slot compare unit
   typedef struct packed {
      logic key_hit;
      logic at_or_above;
   } cmp_type;

endpackage

### hdl/brt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/brt_cmp.sv
// Shared slot compare unit: key match and score at-or-above test.
module brt_cmp
   import brt_pkg::*;
#(
   parameter int KW = DEF_KEY_BITS
) (
   input  logic [KW-1:0]             slot_key,
   input  logic signed [SCORE_W-1:0] slot_score,
   input  logic [KW-1:0]             qry_key,
   input  logic signed [SCORE_W-1:0] qry_score,
   output cmp_type                   result
);

   // Compare one slot against the held query
   assign result.key_hit     = (slot_key == qry_key);
   assign result.at_or_above = (slot_score >= qry_score);

endmodule

### hdl/bounded_ranking_table.sv
// Top level of the bounded ranking table: sequencer, slot RAM and registers.
//
// A leaderboard of up to POOL_DEPTH entries kept in a RAM, sorted by higher
// score first, equal scores in order of writing. Commands arrive on the req_
// channel (valid/ready) and each gives exactly one transfer on the rsp_
// channel (valid/ready). Registers min_score, max_score and pool_size are
// written through the csr_ port, one write per cycle. The user writes them
// only while the block is idle; the block itself does not enforce this.
//
// One command at a time: req_ready is high only while the sequencer is idle.
// Every command except entry-at-rank first scans the N stored entries through
// the single RAM read port and the shared compare unit. An update or remove
// may then shift the tail of the row, one entry per cycle, and an insert
// then writes the new entry at its place. Entry at rank reads at most the
// one slot at the asked rank. The time per command is set by the one RAM
// port that every slot visit goes through.
//
// Reset empties the board (entry count zero, no clearing pass) and loads the
// register reset values. A finished result waits in the output register; a
// stalled receiver holds the sequencer before its next result only.
module bounded_ranking_table
   import brt_pkg::*;
#(
   parameter int POOL_DEPTH = DEF_POOL_DEPTH,
   parameter int KEY_BITS   = DEF_KEY_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [CMD_W-1:0]            req_cmd,
   input  logic [KEY_PORT_W-1:0]       req_key,
   input  logic signed [SCORE_W-1:0]   req_score,
   input  logic [RANK_W-1:0]           req_rank_query,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [RANK_W-1:0]           rsp_rank,
   output logic                        rsp_found,
   output logic [KEY_PORT_W-1:0]       rsp_key_out,
   output logic signed [SCORE_W-1:0]   rsp_score_out,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [SCORE_W-1:0]          csr_wdata
);

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int LW = ((CW > PSIZE_W) ? CW : PSIZE_W) + 1;
   localparam int KW = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
   localparam int SW = KW + SCORE_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SHL    = 3'd3;
   localparam logic [2:0] S_SHRI   = 3'd4;
   localparam logic [2:0] S_SHR    = 3'd5;
   localparam logic [2:0] S_INS    = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic                       fetch_ff, fetch_in;
   logic [CMD_W-1:0]           cmd_ff, cmd_in;
   logic [KW-1:0]              key_ff, key_in;
   logic signed [SCORE_W-1:0]  score_ff, score_in;
   logic [RANK_W-1:0]          rq_ff, rq_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [CW-1:0]              rd_ff, rd_in;
   logic                       pend_ff, pend_in;
   logic [CW-1:0]              pend_addr_ff, pend_addr_in;
   logic                       hit_ff, hit_in;
   logic [CW-1:0]              pos_ff, pos_in;
   logic signed [SCORE_W-1:0]  old_ff, old_in;
   logic [CW-1:0]              ge_ff, ge_in;
   logic [CW-1:0]              ins_pos_ff, ins_pos_in;
   logic                       do_ins_ff, do_ins_in;
   logic [RANK_W-1:0]          res_rank_ff, res_rank_in;
   logic                       res_found_ff, res_found_in;
   logic [KEY_PORT_W-1:0]      res_key_ff, res_key_in;
   logic signed [SCORE_W-1:0]  res_score_ff, res_score_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]          rsp_rank_ff, rsp_rank_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic [KEY_PORT_W-1:0]      rsp_key_ff, rsp_key_in;
   logic signed [SCORE_W-1:0]  rsp_score_ff, rsp_score_in;
   logic signed [SCORE_W-1:0]  min_ff, min_in;
   logic signed [SCORE_W-1:0]  max_ff, max_in;
   logic [PSIZE_W-1:0]         psize_ff, psize_in;

   logic                       ram_wr_en;
   logic [IW-1:0]              ram_wr_addr;
   logic [SW-1:0]              ram_wr_data;
   logic                       ram_rd_en;
   logic [IW-1:0]              ram_rd_addr;
   logic [SW-1:0]              ram_rd_data;
   logic [KW-1:0]              slot_key;
   logic signed [SCORE_W-1:0]  slot_score;
   cmp_type                    cmp;

   logic [LW-1:0]              limit;
   logic                       in_bounds;
   logic [CW-1:0]              place;
   logic [CW-1:0]              last;
   logic [LW-1:0]              grown;
   logic [LW-1:0]              new_cnt;
   logic                       q_ok;
   logic [LW-1:0]              rq_m1;
   logic [CW-1:0]              rd_m1;
   logic                       fwd_issue;
   logic                       shr_issue;
   logic                       fetch_issue;

   // Slot storage: key and score side by side
   brt_ram #(.WIDTH(SW), .DEPTH(POOL_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign slot_key   = ram_rd_data[SW-1:SCORE_W];
   assign slot_score = signed'(ram_rd_data[SCORE_W-1:0]);

   brt_cmp #(.KW(KW)) u_cmp (
      .slot_key   (slot_key),
      .slot_score (slot_score),
      .qry_key    (key_ff),
      .qry_score  (score_ff),
      .result     (cmp)
   );

   // Effective pool limit: zero acts as one, clamp at the depth
   always_comb begin
      if (psize_ff == '0) begin
         limit = LW'(1);
      end else if (LW'(psize_ff) > LW'(POOL_DEPTH)) begin
         limit = LW'(POOL_DEPTH);
      end else begin
         limit = LW'(psize_ff);
      end
   end

   // Decision helpers
   assign in_bounds = (score_ff > min_ff) && (score_ff < max_ff);
   assign place     = ge_ff - CW'(hit_ff && (old_ff >= score_ff));
   assign last      = (cnt_ff < CW'(POOL_DEPTH)) ? cnt_ff : CW'(POOL_DEPTH - 1);
   assign grown     = LW'(last) + LW'(1);
   assign new_cnt   = (grown > limit) ? limit : grown;
   assign q_ok      = (rq_ff != '0) && (LW'(rq_ff) <= LW'(cnt_ff));
   assign rq_m1     = LW'(rq_ff) - LW'(1);
   assign rd_m1     = rd_ff - CW'(1);

   // Read issue of the scan, left shift, right shift and rank fetch
   assign fwd_issue   = ((state_ff == S_SCAN) || (state_ff == S_SHL)) && (rd_ff < cnt_ff);
   assign shr_issue   = (state_ff == S_SHR) && (rd_ff > ins_pos_ff);
   assign fetch_issue = fetch_ff && !pend_ff && q_ok;
   assign ram_rd_en   = fwd_issue || shr_issue || fetch_issue;

   always_comb begin
      if (fetch_ff) begin
         ram_rd_addr = rq_m1[IW-1:0];
      end else if (state_ff == S_SHR) begin
         ram_rd_addr = rd_m1[IW-1:0];
      end else begin
         ram_rd_addr = rd_ff[IW-1:0];
      end
   end

   // Write: pending shifted entry, or the new entry at its place
   assign ram_wr_en   = (((state_ff == S_SHL) || (state_ff == S_SHR)) && pend_ff) ||
                        (state_ff == S_INS);
   assign ram_wr_addr = (state_ff == S_INS) ? ins_pos_ff[IW-1:0] : pend_addr_ff[IW-1:0];
   assign ram_wr_data = (state_ff == S_INS) ? {key_ff, score_ff} : ram_rd_data;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fetch_in     = fetch_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      score_in     = score_ff;
      rq_in        = rq_ff;
      cnt_in       = cnt_ff;
      rd_in        = rd_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      hit_in       = hit_ff;
      pos_in       = pos_ff;
      old_in       = old_ff;
      ge_in        = ge_ff;
      ins_pos_in   = ins_pos_ff;
      do_ins_in    = do_ins_ff;
      res_rank_in  = res_rank_ff;
      res_found_in = res_found_ff;
      res_key_in   = res_key_ff;
      res_score_in = res_score_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_found_in = rsp_found_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_score_in = rsp_score_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      psize_in     = psize_ff;

      // Register writes
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_SCORE: min_in   = signed'(csr_wdata);
            CSR_MAX_SCORE: max_in   = signed'(csr_wdata);
            CSR_POOL_SIZE: psize_in = csr_wdata[PSIZE_W-1:0];
            default: ;
         endcase
      end

      // Drop the result once transferred
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (fetch_ff) begin
         // Entry at rank: one read if the rank is in range, then report
         if (!pend_ff) begin
            if (q_ok) begin
               pend_in = 1'b1;
            end else begin
               res_rank_in  = '0;
               res_found_in = 1'b0;
               res_key_in   = '0;
               res_score_in = '0;
               fetch_in     = 1'b0;
               state_in     = S_OUT;
            end
         end else begin
            pend_in      = 1'b0;
            res_rank_in  = rq_ff;
            res_found_in = 1'b1;
            res_key_in   = KEY_PORT_W'(slot_key);
            res_score_in = slot_score;
            fetch_in     = 1'b0;
            state_in     = S_OUT;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_in    = req_cmd;
                  key_in    = req_key[KW-1:0];
                  score_in  = req_score;
                  rq_in     = req_rank_query;
                  rd_in     = '0;
                  pend_in   = 1'b0;
                  hit_in    = 1'b0;
                  pos_in    = '0;
                  ge_in     = '0;
                  do_ins_in = 1'b0;
                  if (req_cmd == CMD_AT_RANK) begin
                     fetch_in = 1'b1;
                     state_in = S_SCAN;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               // Visit every stored entry through the compare unit
               if (fwd_issue) begin
                  rd_in = rd_ff + CW'(1);
               end
               pend_in      = fwd_issue;
               pend_addr_in = rd_ff;
               if (pend_ff) begin
                  if (cmp.key_hit) begin
                     hit_in = 1'b1;
                     pos_in = pend_addr_ff;
                     old_in = slot_score;
                  end
                  if (cmp.at_or_above) begin
                     ge_in = ge_ff + CW'(1);
                  end
               end
               if (!fwd_issue && !pend_ff) begin
                  state_in = S_DECIDE;
               end
            end
            S_DECIDE: begin
               res_rank_in  = '0;
               res_found_in = 1'b0;
               res_key_in   = '0;
               res_score_in = '0;
               state_in     = S_OUT;
               pend_in      = 1'b0;
               rd_in        = pos_ff + CW'(1);
               case (cmd_ff)
                  CMD_UPDATE: begin
                     if (hit_ff && (old_ff == score_ff)) begin
                        res_rank_in  = RANK_W'(LW'(pos_ff) + LW'(1));
                        res_found_in = 1'b1;
                        res_key_in   = KEY_PORT_W'(key_ff);
                        res_score_in = score_ff;
                     end else begin
                        if (in_bounds && (LW'(place) >= limit)) begin
                           res_rank_in = RANK_W'(limit + LW'(1));
                        end else if (in_bounds) begin
                           res_rank_in  = RANK_W'(LW'(place) + LW'(1));
                           res_found_in = 1'b1;
                           res_key_in   = KEY_PORT_W'(key_ff);
                           res_score_in = score_ff;
                           do_ins_in    = 1'b1;
                           ins_pos_in   = place;
                        end
                        if (hit_ff) begin
                           state_in = S_SHL;
                        end else if (in_bounds && (LW'(place) < limit)) begin
                           state_in = S_SHRI;
                        end
                     end
                  end
                  CMD_REMOVE: begin
                     if (hit_ff) begin
                        res_found_in = 1'b1;
                        res_key_in   = KEY_PORT_W'(key_ff);
                        res_score_in = old_ff;
                        state_in     = S_SHL;
                     end
                  end
                  CMD_RANK_KEY: begin
                     if (hit_ff) begin
                        res_rank_in  = RANK_W'(LW'(pos_ff) + LW'(1));
                        res_found_in = 1'b1;
                        res_key_in   = KEY_PORT_W'(key_ff);
                        res_score_in = old_ff;
                     end
                  end
                  CMD_RANK_SCORE: begin
                     res_rank_in = RANK_W'(LW'(ge_ff) + LW'(1));
                  end
                  default: ;
               endcase
            end
            S_SHL: begin
               // Close the gap: move each later entry down by one
               if (fwd_issue) begin
                  rd_in = rd_ff + CW'(1);
               end
               pend_in      = fwd_issue;
               pend_addr_in = rd_m1;
               if (!fwd_issue && !pend_ff) begin
                  cnt_in   = cnt_ff - CW'(1);
                  state_in = do_ins_ff ? S_SHRI : S_OUT;
               end
            end
            S_SHRI: begin
               rd_in    = last;
               pend_in  = 1'b0;
               state_in = S_SHR;
            end
            S_SHR: begin
               // Open a gap: move entries up by one from the tail
               if (shr_issue) begin
                  rd_in = rd_m1;
               end
               pend_in      = shr_issue;
               pend_addr_in = rd_ff;
               if (!shr_issue && !pend_ff) begin
                  state_in = S_INS;
               end
            end
            S_INS: begin
               cnt_in   = CW'(new_cnt);
               state_in = S_OUT;
            end
            S_OUT: begin
               // Hand the result to the output register once it is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_in = 1'b1;
                  rsp_rank_in  = res_rank_ff;
                  rsp_found_in = res_found_ff;
                  rsp_key_in   = res_key_ff;
                  rsp_score_in = res_score_ff;
                  state_in     = S_IDLE;
               end
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fetch_ff     <= 1'b0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= MIN_SCORE_RST;
         max_ff       <= MAX_SCORE_RST;
         psize_ff     <= POOL_SIZE_RST;
      end else begin
         state_ff     <= state_in;
         fetch_ff     <= fetch_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         psize_ff     <= psize_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      score_ff     <= score_in;
      rq_ff        <= rq_in;
      rd_ff        <= rd_in;
      pend_addr_ff <= pend_addr_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      old_ff       <= old_in;
      ge_ff        <= ge_in;
      ins_pos_ff   <= ins_pos_in;
      do_ins_ff    <= do_ins_in;
      res_rank_ff  <= res_rank_in;
      res_found_ff <= res_found_in;
      res_key_ff   <= res_key_in;
      res_score_ff <= res_score_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_found_ff <= rsp_found_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign req_ready     = (state_ff == S_IDLE) && !fetch_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rank      = rsp_rank_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_key_out   = rsp_key_ff;
   assign rsp_score_out = rsp_score_ff;

endmodule

### hdl/brt_checker.sv
// Port-level checker of the bounded ranking table, bound to the top level.
module brt_checker
   import brt_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_found,
   input logic [KEY_PORT_W-1:0]     rsp_key_out,
   input logic signed [SCORE_W-1:0] rsp_score_out
);

   // Result held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Nothing to deliver straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   // One command at a time: busy after each accepted transfer
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command accepted while another is in work");

   // A miss reports no entry
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_key_out == '0) && (rsp_score_out == '0))
      else $error("miss carries entry data");

endmodule

bind bounded_ranking_table brt_checker u_brt_checker (.*);
